// ===== design/lcp_pkg.sv =====
`timescale 1ns / 1ps

package lcp_pkg;

  // Field widths
  localparam int AMP_W      = 14;
  localparam int TRK_W      = 10;
  localparam int E_W        = 15;
  localparam int ESUM_W     = 18;
  localparam int X_W        = 14;
  localparam int ST_W       = 2;
  localparam int LOG_W      = 17;
  localparam int WT_W       = 16;
  localparam int POS_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NCRY       = 9;

  // Reciprocal shift for the gain division
  localparam int RCP_SH = 27;

  localparam longint unsigned LN2_Q16 = 64'd45426;

  // Per-crystal gains, row by row, left to right
  localparam logic [12:0] GAIN [NCRY] = '{
    13'd3700, 13'd3480, 13'd3400,
    13'd4260, 13'd3970, 13'd3810,
    13'd3730, 13'd3640, 13'd3780
  };

  localparam logic [12:0] GAIN_HALF [NCRY] = '{
    13'd1850, 13'd1740, 13'd1700,
    13'd2130, 13'd1985, 13'd1905,
    13'd1865, 13'd1820, 13'd1890
  };

  localparam logic [15:0] GAIN_RCP [NCRY] = '{
    16'(134217728 / 3700), 16'(134217728 / 3480), 16'(134217728 / 3400),
    16'(134217728 / 4260), 16'(134217728 / 3970), 16'(134217728 / 3810),
    16'(134217728 / 3730), 16'(134217728 / 3640), 16'(134217728 / 3780)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_OFFSET  = 3'd0,
    REG_CRYS_THR    = 3'd1,
    REG_SEED_MIN    = 3'd2,
    REG_TRACK_MIN   = 3'd3,
    REG_COL_LEFT    = 3'd4,
    REG_COL_MID     = 3'd5,
    REG_COL_RIGHT   = 3'd6
  } reg_idx_t;

  typedef enum logic [ST_W-1:0] {
    ST_VALID     = 2'd0,
    ST_CUT       = 2'd1,
    ST_NO_WEIGHT = 2'd2
  } status_t;

  // ln(num/den) in Q4.12, rounded, for 0 < num <= den; evaluated at elaboration
  function automatic logic signed [LOG_W-1:0] log_q12(input longint unsigned num,
                                                       input longint unsigned den);
    longint unsigned k;
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    longint unsigned m;
    longint unsigned l2;
    longint unsigned mag;
    k = 0;
    for (int j = 0; j < 40; j++) begin
      if ((num << (k + 1)) <= den) k = k + 1;
    end
    // long division of den<<30 by num<<k
    a = den << 30;
    b = num << k;
    r = 0;
    m = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & 64'd1);
      if (r >= b) begin
        r = r - b;
        m = m | (64'd1 << i);
      end
    end
    l2 = k << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        l2 = l2 | (64'd1 << i);
      end
    end
    mag = (l2 * LN2_Q16 + (64'd1 << 19)) >> 20;
    return -($signed(LOG_W'(mag)));
  endfunction

endpackage

// ===== design/lcp_ifs.sv =====
`timescale 1ns / 1ps

interface lcp_in_if import lcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AMP_W-1:0] amp_r1_left;
  logic [AMP_W-1:0] amp_r1_center;
  logic [AMP_W-1:0] amp_r1_right;
  logic [AMP_W-1:0] amp_r2_left;
  logic [AMP_W-1:0] amp_r2_center;
  logic [AMP_W-1:0] amp_r2_right;
  logic [AMP_W-1:0] amp_r3_left;
  logic [AMP_W-1:0] amp_r3_center;
  logic [AMP_W-1:0] amp_r3_right;
  logic signed [TRK_W-1:0] track_x;

  modport source (output valid, amp_r1_left, amp_r1_center, amp_r1_right,
                  amp_r2_left, amp_r2_center, amp_r2_right,
                  amp_r3_left, amp_r3_center, amp_r3_right, track_x,
                  input ready);
  modport sink (input valid, amp_r1_left, amp_r1_center, amp_r1_right,
                amp_r2_left, amp_r2_center, amp_r2_right,
                amp_r3_left, amp_r3_center, amp_r3_right, track_x,
                output ready);
endinterface

interface lcp_out_if import lcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [X_W-1:0]    cluster_x;
  logic [ESUM_W-1:0] cluster_energy;
  logic [ST_W-1:0]   status;

  modport source (output valid, cluster_x, cluster_energy, status, input ready);
  modport sink (input valid, cluster_x, cluster_energy, status, output ready);
endinterface

interface lcp_cfg_if import lcp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/lcp_divpipe.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, one stage per enable bit.
module lcp_divpipe #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 20,
  parameter int Q_W   = 14
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   en,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [Q_W-1:0]   quo_out
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int K = Q_W - 1 - j;
    logic [NUM_W-1:0] rem_src;
    logic [DEN_W-1:0] den_src;
    logic [Q_W-1:0]   quo_src;
    logic [CW-1:0]    dsh;
    logic             take;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (j == 0) begin : g_first
      assign rem_src = num_in;
      assign den_src = den_in;
      assign quo_src = '0;
    end else begin : g_rest
      assign rem_src = rem_r[j-1];
      assign den_src = den_r[j-1];
      assign quo_src = quo_r[j-1];
    end

    // compare against the shifted divisor and subtract on success
    always_comb begin
      dsh     = CW'(den_src) << K;
      take    = CW'(rem_src) >= dsh;
      rem_nxt = take ? NUM_W'(CW'(rem_src) - dsh) : rem_src;
      quo_nxt = quo_src;
      quo_nxt[K] = take;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_src;
        quo_r[j] <= quo_nxt;
      end
    end
  end

  assign quo_out = quo_r[Q_W-1];

endmodule

// ===== design/log_weighted_cluster_position.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Beat contents
// in_bus   in   valid/ready    nine crystal amplitudes, track_x
// out_bus  out  valid/ready    cluster_x, cluster_energy, status
// cfg_bus  in   valid/ready    register index, write data (ready tied high)
//
// One event enters per cycle while out_bus is not stalled; the two
// bit-per-stage dividers make up most of the pipeline stages.
// Reset (synchronous, rst_n low) clears the stage valid bits and loads the
// register defaults. A stall on out_bus ripples back stage by stage through
// the valid bits, so empty stages keep filling and nothing is lost or repeated.
module log_weighted_cluster_position import lcp_pkg::*; #(
  parameter int LOG_TABLE_ENTRIES = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  lcp_in_if.sink  in_bus,
  lcp_out_if.source out_bus,
  lcp_cfg_if.sink cfg_bus
);

  localparam int QB     = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int IW     = $clog2(LOG_TABLE_ENTRIES);
  localparam int RW     = E_W + QB;
  localparam int WX_W   = POS_W + WT_W + 4;
  localparam int WS_W   = WT_W + 4;
  localparam int NUM_W  = WX_W + 6;

  localparam int S_PROD = 0;
  localparam int S_QUO  = 1;
  localparam int S_CAL  = 2;
  localparam int S_THR  = 3;
  localparam int S_ESUM = 4;
  localparam int S_IDIV = 5;
  localparam int S_LOG  = S_IDIV + QB;
  localparam int S_MUL  = S_LOG + 1;
  localparam int S_SUM1 = S_LOG + 2;
  localparam int S_SUM2 = S_LOG + 3;
  localparam int S_XDIV = S_LOG + 4;
  localparam int S_OUT  = S_XDIV + X_W;
  localparam int NST    = S_OUT + 1;

  // ---------------------------------------------------------------- config
  logic [15:0]             log_offset_r;
  logic [15:0]             crys_thr_r;
  logic [AMP_W-1:0]        seed_min_r;
  logic signed [TRK_W-1:0] track_min_r;
  logic [POS_W-1:0]        col_pos_r [3];

  assign cfg_bus.ready = 1'b1;

  // write registers; ignore an index beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_offset_r <= 16'd15565;
      crys_thr_r   <= 16'd602;
      seed_min_r   <= 14'd1000;
      track_min_r  <= -10'sd80;
      col_pos_r[0] <= 8'd22;
      col_pos_r[1] <= 8'd44;
      col_pos_r[2] <= 8'd66;
    end else if (cfg_bus.valid) begin
      unique case (reg_idx_t'(cfg_bus.index))
        REG_LOG_OFFSET: log_offset_r <= cfg_bus.data;
        REG_CRYS_THR:   crys_thr_r   <= cfg_bus.data;
        REG_SEED_MIN:   seed_min_r   <= cfg_bus.data[AMP_W-1:0];
        REG_TRACK_MIN:  track_min_r  <= $signed(cfg_bus.data[TRK_W-1:0]);
        REG_COL_LEFT:   col_pos_r[0] <= cfg_bus.data[POS_W-1:0];
        REG_COL_MID:    col_pos_r[1] <= cfg_bus.data[POS_W-1:0];
        REG_COL_RIGHT:  col_pos_r[2] <= cfg_bus.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- log table
  logic signed [LOG_W-1:0] log_tab [LOG_TABLE_ENTRIES];

  for (genvar t = 0; t < LOG_TABLE_ENTRIES; t++) begin : g_tab
    localparam logic signed [LOG_W-1:0] LV =
      log_q12(64'(2 * t + 1), 64'(2 * LOG_TABLE_ENTRIES));
    assign log_tab[t] = LV;
  end

  // --------------------------------------------------------- stage control
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] en;

  assign en[NST-1] = !vld_r[NST-1] || out_bus.ready;
  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = !vld_r[s] || en[s+1];
  end

  assign in_bus.ready = en[S_PROD];
  assign vld_nxt = {vld_r[NST-2:0], in_bus.valid};

  // advance valid bits stage by stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (en[s]) vld_r[s] <= vld_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------- input stage
  logic [AMP_W-1:0] amp_in [NCRY];
  logic             cut_in;

  assign amp_in[0] = in_bus.amp_r1_left;
  assign amp_in[1] = in_bus.amp_r1_center;
  assign amp_in[2] = in_bus.amp_r1_right;
  assign amp_in[3] = in_bus.amp_r2_left;
  assign amp_in[4] = in_bus.amp_r2_center;
  assign amp_in[5] = in_bus.amp_r2_right;
  assign amp_in[6] = in_bus.amp_r3_left;
  assign amp_in[7] = in_bus.amp_r3_center;
  assign amp_in[8] = in_bus.amp_r3_right;

  assign cut_in = (in_bus.amp_r1_center <= seed_min_r) ||
                  ($signed(in_bus.track_x) <= track_min_r);

  // calibration: multiply by gain reciprocal
  logic [41:0]      prod_r [NCRY];
  logic [AMP_W-1:0] amp0_r [NCRY];

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      for (int i = 0; i < NCRY; i++) begin
        prod_r[i] <= 42'({amp_in[i], 12'd0} + 26'(GAIN_HALF[i])) * 42'(GAIN_RCP[i]);
        amp0_r[i] <= amp_in[i];
      end
    end
  end

  // estimate quotient, multiply back by gain
  logic [E_W-1:0]   q0_r   [NCRY];
  logic [27:0]      qg_r   [NCRY];
  logic [AMP_W-1:0] amp1_r [NCRY];

  always_ff @(posedge clk) begin
    if (en[S_QUO]) begin
      for (int i = 0; i < NCRY; i++) begin
        q0_r[i]   <= prod_r[i][RCP_SH +: E_W];
        qg_r[i]   <= 28'(prod_r[i][RCP_SH +: E_W]) * 28'(GAIN[i]);
        amp1_r[i] <= amp0_r[i];
      end
    end
  end

  // correct the estimate by at most one
  logic [E_W-1:0] e_r [NCRY];

  always_ff @(posedge clk) begin
    if (en[S_CAL]) begin
      for (int i = 0; i < NCRY; i++) begin
        e_r[i] <= q0_r[i] + E_W'(({amp1_r[i], 12'd0} + 26'(GAIN_HALF[i])
                                 - qg_r[i][25:0]) >= 26'(GAIN[i]));
      end
    end
  end

  // threshold and partial sums by row
  logic [E_W-1:0]  e3_r  [NCRY];
  logic [NCRY-1:0] pass_thr;
  logic [E_W+1:0]  grp_r [3];

  always_comb begin
    for (int i = 0; i < NCRY; i++) pass_thr[i] = 16'(e_r[i]) > crys_thr_r;
  end

  always_ff @(posedge clk) begin
    if (en[S_THR]) begin
      for (int i = 0; i < NCRY; i++) e3_r[i] <= e_r[i];
      for (int r = 0; r < 3; r++) begin
        grp_r[r] <= (pass_thr[3*r]   ? (E_W+2)'(e_r[3*r])   : '0) +
                    (pass_thr[3*r+1] ? (E_W+2)'(e_r[3*r+1]) : '0) +
                    (pass_thr[3*r+2] ? (E_W+2)'(e_r[3*r+2]) : '0);
      end
    end
  end

  // total energy and numerators for the fraction index
  logic [ESUM_W-1:0] esum4;
  logic [RW-1:0]     frac_num_r [NCRY];

  assign esum4 = ESUM_W'(grp_r[0]) + ESUM_W'(grp_r[1]) + ESUM_W'(grp_r[2]);

  always_ff @(posedge clk) begin
    if (en[S_ESUM]) begin
      for (int i = 0; i < NCRY; i++) begin
        frac_num_r[i] <= RW'(e3_r[i]) * RW'(LOG_TABLE_ENTRIES);
      end
    end
  end

  // carry pass bits, cut flag, energy and zero-weight flag along
  logic [NCRY-1:0]   pass_c_r [S_LOG-1:S_THR];
  logic              cut_c_r  [S_OUT-1:S_PROD];
  logic [ESUM_W-1:0] esum_c_r [S_OUT-1:S_ESUM];
  logic              zw_c_r   [S_OUT-1:S_SUM2];
  logic              zw_sum;

  for (genvar s = S_THR; s < S_LOG; s++) begin : g_pass
    if (s == S_THR) begin : g_head
      always_ff @(posedge clk) if (en[s]) pass_c_r[s] <= pass_thr;
    end else begin : g_body
      always_ff @(posedge clk) if (en[s]) pass_c_r[s] <= pass_c_r[s-1];
    end
  end

  for (genvar s = S_PROD; s < S_OUT; s++) begin : g_cut
    if (s == S_PROD) begin : g_head
      always_ff @(posedge clk) if (en[s]) cut_c_r[s] <= cut_in;
    end else begin : g_body
      always_ff @(posedge clk) if (en[s]) cut_c_r[s] <= cut_c_r[s-1];
    end
  end

  for (genvar s = S_ESUM; s < S_OUT; s++) begin : g_esum
    if (s == S_ESUM) begin : g_head
      always_ff @(posedge clk) if (en[s]) esum_c_r[s] <= esum4;
    end else begin : g_body
      always_ff @(posedge clk) if (en[s]) esum_c_r[s] <= esum_c_r[s-1];
    end
  end

  for (genvar s = S_SUM2; s < S_OUT; s++) begin : g_zw
    if (s == S_SUM2) begin : g_head
      always_ff @(posedge clk) if (en[s]) zw_c_r[s] <= zw_sum;
    end else begin : g_body
      always_ff @(posedge clk) if (en[s]) zw_c_r[s] <= zw_c_r[s-1];
    end
  end

  // fraction index dividers, one per crystal
  logic [QB-1:0] frac_q [NCRY];

  for (genvar i = 0; i < NCRY; i++) begin : g_fdiv
    lcp_divpipe #(
      .NUM_W (RW),
      .DEN_W (ESUM_W),
      .Q_W   (QB)
    ) u_fdiv (
      .clk     (clk),
      .en      (en[S_IDIV +: QB]),
      .num_in  (frac_num_r[i]),
      .den_in  (esum_c_r[S_ESUM]),
      .quo_out (frac_q[i])
    );
  end

  // weight = offset + log fraction, keep positive ones of crystals above threshold only
  logic [WT_W-1:0] ww_r [NCRY];

  always_ff @(posedge clk) begin
    if (en[S_LOG]) begin
      for (int i = 0; i < NCRY; i++) begin
        logic [IW-1:0]      idx;
        logic signed [17:0] w;
        idx = (frac_q[i] >= QB'(LOG_TABLE_ENTRIES)) ? IW'(LOG_TABLE_ENTRIES - 1)
                                                    : frac_q[i][IW-1:0];
        w = $signed({2'b00, log_offset_r}) + 18'(log_tab[idx]);
        ww_r[i] <= (pass_c_r[S_LOG-1][i] && (w > 18'sd0)) ? w[WT_W-1:0] : '0;
      end
    end
  end

  // position times weight
  logic [POS_W+WT_W-1:0] pxw_r [NCRY];
  logic [WT_W-1:0]       ww2_r [NCRY];

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      for (int i = 0; i < NCRY; i++) begin
        pxw_r[i] <= (POS_W+WT_W)'(col_pos_r[i % 3]) * (POS_W+WT_W)'(ww_r[i]);
        ww2_r[i] <= ww_r[i];
      end
    end
  end

  // partial sums of moment, total weight
  logic [WX_W-1:0] wxg_r [3];
  logic [WS_W-1:0] wsum_r;
  logic [WS_W-1:0] wsum_comb;

  always_comb begin
    wsum_comb = '0;
    for (int i = 0; i < NCRY; i++) wsum_comb = wsum_comb + WS_W'(ww2_r[i]);
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM1]) begin
      for (int r = 0; r < 3; r++) begin
        wxg_r[r] <= WX_W'(pxw_r[3*r]) + WX_W'(pxw_r[3*r+1]) + WX_W'(pxw_r[3*r+2]);
      end
      wsum_r <= wsum_comb;
    end
  end

  // rounded position numerator
  logic [NUM_W-1:0] xnum_r;
  logic [WS_W-1:0]  wsumd_r;

  assign zw_sum = (wsum_r == '0);

  always_ff @(posedge clk) begin
    if (en[S_SUM2]) begin
      xnum_r  <= {wxg_r[0] + wxg_r[1] + wxg_r[2], 6'd0} + NUM_W'(wsum_r >> 1);
      wsumd_r <= wsum_r;
    end
  end

  logic [X_W-1:0] x_q;

  lcp_divpipe #(
    .NUM_W (NUM_W),
    .DEN_W (WS_W),
    .Q_W   (X_W)
  ) u_xdiv (
    .clk     (clk),
    .en      (en[S_XDIV +: X_W]),
    .num_in  (xnum_r),
    .den_in  (wsumd_r),
    .quo_out (x_q)
  );

  // ---------------------------------------------------------- output stage
  logic [X_W-1:0]    x_r;
  logic [ESUM_W-1:0] energy_r;
  status_t           status_r;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      if (cut_c_r[S_OUT-1]) begin
        x_r      <= '0;
        energy_r <= '0;
        status_r <= ST_CUT;
      end else if (zw_c_r[S_OUT-1]) begin
        x_r      <= '0;
        energy_r <= esum_c_r[S_OUT-1];
        status_r <= ST_NO_WEIGHT;
      end else begin
        x_r      <= x_q;
        energy_r <= esum_c_r[S_OUT-1];
        status_r <= ST_VALID;
      end
    end
  end

  assign out_bus.valid          = vld_r[S_OUT];
  assign out_bus.cluster_x      = x_r;
  assign out_bus.cluster_energy = energy_r;
  assign out_bus.status         = status_r;

  // ------------------------------------------------------------ assertions
  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && (status_r == ST_CUT) |-> (x_r == '0) && (energy_r == '0))
    else $error("cut event carries nonzero result");

  a_noweight_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && (status_r == ST_NO_WEIGHT) |-> (x_r == '0))
    else $error("no-weight event carries nonzero position");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.ready |-> in_bus.ready)
    else $error("pipeline stalls while output drains");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> vld_r[S_PROD])
    else $error("accepted beat missing from first stage");

endmodule
